// ----- rtl/core/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the packet ring queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int SLOT_BYTES_DEF = 2048;
  localparam int LIMIT_W        = 12;
  localparam int BYTE_W         = 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NONE  = 2'd2,
    ST_PUSH  = 2'd3
  } status_t;

endpackage

// ----- rtl/core/prq_ram.sv -----
// ----------------------------------------------------------------------------
// prq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prq_ram import prq_pkg::*; #(
  parameter int DEPTH = SLOTS_DEF,
  parameter int WIDTH = BYTE_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/packet_ring_queue_top.sv -----
// ----------------------------------------------------------------------------
// packet_ring_queue_top
// Ring of packet slots in a byte RAM with a length RAM per slot; one byte per
// push or pop transfer, one result per transfer.
// ----------------------------------------------------------------------------
// states: push runs capture, execute and hold; pop runs capture, execute,
// data and hold, and the first pop of a packet adds a slot length RAM read
// (a zero bound goes from the length read straight to hold); empty pop runs
// capture, execute and hold; the single RAM access sequencer handles one item at a time
// reset: synchronous active low, clears pointers, counters and flags;
// RAM contents are not cleared
module packet_ring_queue_top import prq_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF,
  localparam int CNT_W     = $clog2(SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_push_last,
  input  logic [LIMIT_W-1:0] in_read_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic [CNT_W-1:0]   out_occupancy
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
  localparam int OFF_W  = $clog2(SLOT_BYTES);
  localparam int DEPTH  = SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LEN,
    S_DATA,
    S_HOLD
  } state_t;

  state_t               state_r;
  logic                 op_r;
  logic [BYTE_W-1:0]    byte_r;
  logic                 last_r;
  logic [LIMIT_W-1:0]   limit_r;

  logic [SLOT_W-1:0]    head_r;
  logic [CNT_W-1:0]     held_r;
  logic [LEN_W-1:0]     woff_r;
  logic                 drop_r;
  logic [LEN_W-1:0]     roff_r;
  logic                 ract_r;
  logic [LEN_W-1:0]     rbound_r;

  status_t              res_status_r;
  logic [BYTE_W-1:0]    res_byte_r;
  logic                 res_last_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;
  logic [CNT_W-1:0]     out_occupancy_r;

  logic [CNT_W:0]       tail_sum;
  logic [SLOT_W-1:0]    tail;
  logic [SLOT_W-1:0]    head_nxt;
  logic [CNT_W-1:0]     held_dec;
  logic                 full_start;
  logic                 dropping;
  logic                 can_store;
  logic [LEN_W-1:0]     woff_nxt;
  logic                 push_exec;
  logic                 pop_exec;
  logic                 byte_we;
  logic                 len_we;
  logic                 len_re;
  logic                 byte_re;
  logic [LEN_W-1:0]     len_rd;
  logic [BYTE_W-1:0]    byte_rd;
  logic [LEN_W-1:0]     new_bound;
  logic [LEN_W-1:0]     eff_bound;
  logic [LEN_W-1:0]     eff_off;
  logic                 pop_skip;
  logic [LEN_W-1:0]     roff_inc;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;

  // tail slot and head advance
  assign tail_sum   = {{(CNT_W + 1 - SLOT_W){1'b0}}, head_r} + {1'b0, held_r};
  assign tail       = (tail_sum >= (CNT_W + 1)'(SLOTS)) ?
                      SLOT_W'(tail_sum - (CNT_W + 1)'(SLOTS)) : SLOT_W'(tail_sum);
  assign head_nxt   = (head_r == SLOT_W'(SLOTS - 1)) ? '0 : head_r + SLOT_W'(1);
  assign held_dec   = held_r - CNT_W'(1);

  // push side
  assign push_exec  = (state_r == S_EXEC) && (op_r == OP_PUSH);
  assign pop_exec   = (state_r == S_EXEC) && (op_r == OP_POP) && (held_r != '0);
  assign full_start = (woff_r == '0) && !drop_r && (held_r >= CNT_W'(SLOTS));
  assign dropping   = drop_r || full_start;
  assign can_store  = woff_r < LEN_W'(SLOT_BYTES);
  assign woff_nxt   = can_store ? woff_r + LEN_W'(1) : woff_r;
  assign byte_we    = push_exec && !dropping && can_store;
  assign len_we     = push_exec && !dropping && last_r;
  assign wr_addr    = ADDR_W'(tail) * ADDR_W'(SLOT_BYTES) + ADDR_W'(woff_r[OFF_W-1:0]);

  // pop side
  assign new_bound  = (CMP_W'(len_rd) < CMP_W'(limit_r)) ? len_rd : LEN_W'(limit_r);
  assign eff_bound  = (state_r == S_LEN) ? new_bound : rbound_r;
  assign eff_off    = (state_r == S_LEN) ? '0 : roff_r;
  assign pop_skip   = (eff_bound == '0) || (eff_off >= eff_bound);
  assign len_re     = pop_exec && !ract_r;
  assign byte_re    = ((pop_exec && ract_r) || (state_r == S_LEN)) && !pop_skip;
  assign rd_addr    = ADDR_W'(head_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(eff_off[OFF_W-1:0]);
  assign roff_inc   = roff_r + LEN_W'(1);

  prq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (BYTE_W)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_we),
    .wr_addr (wr_addr),
    .wr_data (byte_r),
    .rd_en   (byte_re),
    .rd_addr (rd_addr),
    .rd_data (byte_rd)
  );

  prq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LEN_W)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (tail),
    .wr_data (woff_nxt),
    .rd_en   (len_re),
    .rd_addr (head_r),
    .rd_data (len_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      held_r      <= '0;
      woff_r      <= '0;
      drop_r      <= 1'b0;
      roff_r      <= '0;
      ract_r      <= 1'b0;
      rbound_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            byte_r  <= in_byte;
            last_r  <= in_push_last;
            limit_r <= in_read_limit;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_byte_r <= '0;
          res_last_r <= 1'b0;
          if (op_r == OP_PUSH) begin
            res_status_r <= ST_PUSH;
            if (dropping) begin
              drop_r <= !last_r;
            end else if (last_r) begin
              woff_r <= '0;
              held_r <= held_r + CNT_W'(1);
            end else begin
              woff_r <= woff_nxt;
            end
            state_r <= S_HOLD;
          end else if (held_r == '0) begin
            res_status_r <= ST_EMPTY;
            state_r      <= S_HOLD;
          end else if (!ract_r) begin
            state_r <= S_LEN;
          end else if (pop_skip) begin
            res_status_r <= ST_NONE;
            head_r       <= head_nxt;
            held_r       <= held_dec;
            ract_r       <= 1'b0;
            roff_r       <= '0;
            state_r      <= S_HOLD;
          end else begin
            state_r <= S_DATA;
          end
        end
        S_LEN: begin
          rbound_r <= new_bound;
          roff_r   <= '0;
          if (pop_skip) begin
            res_status_r <= ST_NONE;
            head_r       <= head_nxt;
            held_r       <= held_dec;
            ract_r       <= 1'b0;
            state_r      <= S_HOLD;
          end else begin
            ract_r  <= 1'b1;
            state_r <= S_DATA;
          end
        end
        S_DATA: begin
          res_status_r <= ST_BYTE;
          res_byte_r   <= byte_rd;
          if (roff_inc >= rbound_r) begin
            res_last_r <= 1'b1;
            head_r     <= head_nxt;
            held_r     <= held_dec;
            ract_r     <= 1'b0;
            roff_r     <= '0;
          end else begin
            res_last_r <= 1'b0;
            roff_r     <= roff_inc;
          end
          state_r <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= res_status_r;
            out_byte_r      <= res_byte_r;
            out_last_r      <= res_last_r;
            out_occupancy_r <= held_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_occupancy = out_occupancy_r;

endmodule

// ----- rtl/core/prq_checker.sv -----
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the packet ring queue, bound to the top level.
// ----------------------------------------------------------------------------
module prq_checker import prq_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  localparam int CNT_W  = $clog2(SLOTS + 1)
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [BYTE_W-1:0]  out_byte,
  input logic               out_last,
  input logic [CNT_W-1:0]   out_occupancy
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_byte)
      && $stable(out_last) && $stable(out_occupancy))
    else $error("stalled result changed");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= CNT_W'(SLOTS))
    else $error("occupancy above slot count");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_occupancy == '0)
    else $error("empty status with packets held");

  a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_BYTE) |-> (out_byte == '0) && !out_last)
    else $error("byte or last flag without delivered byte");

  // one item in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in progress");

endmodule

bind packet_ring_queue_top prq_checker #(
  .SLOTS (SLOTS)
) u_prq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_byte      (out_byte),
  .out_last      (out_last),
  .out_occupancy (out_occupancy)
);

// ----- verif/packet_ring_queue_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_ring_queue_top_test
// Drives push and pop transfers into the packet ring queue through a burst
// and gap driver, keeps a shadow copy of the slot ring to predict every
// answer, and checks each returned answer field by field against the oldest
// prediction while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module packet_ring_queue_top_test;
  import prq_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int SLOT_BYTES     = SLOT_BYTES_DEF;
  localparam int CNT_W          = $clog2(SLOTS + 1);
  localparam int RANDOM_ITEMS   = 1650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic               op;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [LIMIT_W-1:0] limit;
    bit                 hold;
  } stim_t;

  typedef struct {
    status_t            status;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [CNT_W-1:0]   occ;
  } answer_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               in_operation  = OP_PUSH;
  logic [BYTE_W-1:0]  in_byte       = '0;
  logic               in_push_last  = 1'b0;
  logic [LIMIT_W-1:0] in_read_limit = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         out_status;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic [CNT_W-1:0]   out_occupancy;

  stim_t   stim_items[$];
  answer_t expected_answers[$];
  int      mismatch_cnt = 0;

  // shadow ring
  logic [BYTE_W-1:0] ring_data [SLOTS][SLOT_BYTES];
  int ring_len [SLOTS];
  int head_idx  = 0;
  int held_cnt  = 0;
  int wr_off    = 0;
  bit dropping  = 1'b0;
  int rd_off    = 0;
  bit rd_active = 1'b0;
  int rd_bound  = 0;

  packet_ring_queue_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_byte       (in_byte),
    .in_push_last  (in_push_last),
    .in_read_limit (in_read_limit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_occupancy (out_occupancy)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void retire_head();
    head_idx  = (head_idx + 1) % SLOTS;
    held_cnt  = held_cnt - 1;
    rd_active = 1'b0;
    rd_off    = 0;
  endfunction

  function automatic answer_t ring_answer(input stim_t it);
    answer_t a;
    int      tail;
    a.status = ST_PUSH;
    a.data   = '0;
    a.last   = 1'b0;
    if (it.op == OP_PUSH) begin
      if (wr_off == 0 && !dropping && held_cnt >= SLOTS) dropping = 1'b1;
      if (dropping) begin
        if (it.last) dropping = 1'b0;
      end else begin
        tail = (head_idx + held_cnt) % SLOTS;
        if (wr_off < SLOT_BYTES) begin
          ring_data[tail][wr_off] = it.data;
          wr_off = wr_off + 1;
        end
        if (it.last) begin
          ring_len[tail] = wr_off;
          held_cnt = held_cnt + 1;
          wr_off = 0;
        end
      end
    end else if (held_cnt == 0) begin
      a.status = ST_EMPTY;
    end else begin
      if (!rd_active) begin
        rd_bound  = (ring_len[head_idx] < int'(it.limit)) ? ring_len[head_idx] : int'(it.limit);
        rd_off    = 0;
        rd_active = 1'b1;
      end
      if (rd_bound == 0 || rd_off >= rd_bound) begin
        a.status = ST_NONE;
        retire_head();
      end else begin
        a.status = ST_BYTE;
        a.data   = ring_data[head_idx][rd_off];
        rd_off   = rd_off + 1;
        if (rd_off >= rd_bound) begin
          a.last = 1'b1;
          retire_head();
        end
      end
    end
    a.occ = held_cnt[CNT_W-1:0];
    return a;
  endfunction

  function automatic void queue_item(input logic op, input logic [BYTE_W-1:0] data,
                                     input logic last, input logic [LIMIT_W-1:0] limit,
                                     input bit hold);
    stim_t it;
    it.op    = op;
    it.data  = data;
    it.last  = last;
    it.limit = limit;
    it.hold  = hold;
    stim_items.push_back(it);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    logic [LIMIT_W-1:0] lim;
    case ($urandom_range(0, 9))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = LIMIT_W'(SLOT_BYTES);
      3:       lim = LIMIT_W'($urandom_range(0, 4095));
      default: lim = LIMIT_W'($urandom_range(1, 6));
    endcase
    return lim;
  endfunction

  // driver
  int gap_left   = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    bit go;
    go = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(ring_answer(stim_items.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_items.size() > 0 &&
                     !(stim_items[0].hold && expected_answers.size() > 0)) begin
          go = 1'b1;
          in_operation  <= stim_items[0].op;
          in_byte       <= stim_items[0].data;
          in_push_last  <= stim_items[0].last;
          in_read_limit <= stim_items[0].limit;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= go;
      end
    end
  end

  // monitor, result stall pattern and watchdog
  int stall_style = 0;
  int style_left  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    answer_t exp_a;
    bit      nxt_stall;
    nxt_stall = out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected result status %0d byte %02h last %0b occ %0d",
                     $realtime, out_status, out_byte, out_last, out_occupancy);
          mismatch_cnt++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (out_status !== exp_a.status || out_byte !== exp_a.data ||
              out_last !== exp_a.last || out_occupancy !== exp_a.occ) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch exp status %0d byte %02h last %0b occ %0d, got %0d %02h %0b %0d",
                       $realtime, exp_a.status, exp_a.data, exp_a.last, exp_a.occ,
                       out_status, out_byte, out_last, out_occupancy);
            mismatch_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left  = $urandom_range(50, 200);
      end else begin
        style_left--;
      end
      if (stall_left == 0) begin
        stall_left = $urandom_range(1, 12);
        case (stall_style)
          0:       nxt_stall = 1'b0;
          1:       nxt_stall = ($urandom_range(0, 3) == 0);
          default: nxt_stall = !out_stall;
        endcase
      end else begin
        stall_left--;
      end
    end
    out_stall <= nxt_stall;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("packet_ring_queue_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    int pkt_left;
    int mode;
    int mode_left;
    int push_pct;
    pkt_left  = 0;
    mode      = 0;
    mode_left = 0;

    // directed: empty pop, zero limit, limit above length, push during read
    queue_item(OP_POP, 8'h00, 1'b0, '0, 1'b0);
    queue_item(OP_PUSH, 8'hFF, 1'b0, '1, 1'b0);
    queue_item(OP_PUSH, 8'h00, 1'b1, '0, 1'b0);
    queue_item(OP_POP, 8'hFF, 1'b1, '0, 1'b0);
    queue_item(OP_PUSH, 8'hA5, 1'b0, '0, 1'b0);
    queue_item(OP_PUSH, 8'h5A, 1'b0, '0, 1'b0);
    queue_item(OP_PUSH, 8'hFF, 1'b1, '0, 1'b0);
    queue_item(OP_POP, 8'h00, 1'b0, '1, 1'b0);
    queue_item(OP_PUSH, 8'h3C, 1'b1, '0, 1'b0);
    queue_item(OP_POP, 8'h00, 1'b0, '0, 1'b0);
    queue_item(OP_POP, 8'h00, 1'b0, '0, 1'b0);
    // fill every slot, then a packet that arrives while full is dropped
    for (int i = 0; i < SLOTS - 1; i++)
      queue_item(OP_PUSH, BYTE_W'(i * 17), 1'b1, '0, 1'b0);
    queue_item(OP_PUSH, 8'hC3, 1'b0, '0, 1'b0);
    queue_item(OP_PUSH, 8'h3C, 1'b1, '0, 1'b0);
    queue_item(OP_POP, 8'h00, 1'b0, LIMIT_W'(SLOT_BYTES), 1'b0);

    // drain the ring
    for (int i = 0; i < SLOTS - 1; i++)
      queue_item(OP_POP, 8'h00, 1'b0, LIMIT_W'($urandom_range(1, 4)), (i == 0));

    // random traffic in fill, balanced and drain phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      push_pct = (mode == 0) ? 85 : (mode == 1) ? 50 : 20;
      if ($urandom_range(0, 99) < push_pct) begin
        if (pkt_left == 0)
          pkt_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        pkt_left--;
        queue_item(OP_PUSH, BYTE_W'($urandom_range(0, 255)), (pkt_left == 0),
                   LIMIT_W'($urandom_range(0, 4095)),
                   (n == 0) || ($urandom_range(0, 199) == 0));
      end else begin
        queue_item(OP_POP, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   pick_limit(), (n == 0) || ($urandom_range(0, 199) == 0));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_items.size() > 0) @(posedge clk);
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("packet_ring_queue_top_test: done, clean");
    end else begin
      $display("packet_ring_queue_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/prq_pkg.sv
rtl/core/prq_ram.sv
rtl/core/packet_ring_queue_top.sv
rtl/core/prq_checker.sv
verif/packet_ring_queue_top_test.sv
